FILE: rtl/kfd_pkg.sv
`timescale 1ns / 1ps

package kfd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 1024;

  localparam int BYTE_W = 8;
  localparam int NIB_W  = 4;
  localparam int LEN_W  = 11;
  localparam int KIND_W = 2;

  localparam logic [BYTE_W-1:0] FEND  = 8'hC0;
  localparam logic [BYTE_W-1:0] FESC  = 8'hDB;
  localparam logic [BYTE_W-1:0] TFEND = 8'hDC;
  localparam logic [BYTE_W-1:0] TFESC = 8'hDD;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_AFTER_FEND = 2'd1,
    PH_DATA       = 2'd2,
    PH_ESCAPE     = 2'd3
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    EV_DATA  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ABORT = 2'd2
  } event_t;

endpackage

FILE: rtl/kfd_in_if.sv
`timescale 1ns / 1ps

interface kfd_in_if import kfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/kfd_out_if.sv
`timescale 1ns / 1ps

interface kfd_out_if import kfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [BYTE_W-1:0] data_byte;
  logic [NIB_W-1:0]  port_number;
  logic [NIB_W-1:0]  command_code;
  logic [LEN_W-1:0]  frame_length;
  logic              truncated;

  modport source (
    output valid, output event_kind, output data_byte, output port_number,
    output command_code, output frame_length, output truncated, input ready
  );
  modport sink (
    input valid, input event_kind, input data_byte, input port_number,
    input command_code, input frame_length, input truncated, output ready
  );
endinterface

FILE: rtl/kiss_frame_deframer.sv
`timescale 1ns / 1ps

// channel   | dir | handshake       | payload
// ----------+-----+-----------------+-----------------------------------------------
// in_ch     | in  | valid / ready   | rx_byte
// out_ch    | out | valid / ready   | event_kind, data_byte, port_number,
//           |     |                 | command_code, frame_length, truncated
//
// one byte per cycle unless a stalled output holds back an event byte: a transferred
// byte sits in the input register, is decoded against the phase there and its
// event (if any) is loaded into the output register when that stage advances
// synchronous active-low reset returns to idle with an empty frame
// a stalled output blocks only bytes that produce an event; bytes without an
// event keep flowing into the phase logic while the output register waits

module kiss_frame_deframer import kfd_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  kfd_in_if.sink    in_ch,
  kfd_out_if.source out_ch
);

  localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // input register
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;

  // deframer state
  phase_t            phase_r, phase_nxt;
  logic [NIB_W-1:0]  port_r, port_nxt;
  logic [NIB_W-1:0]  cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;

  // result of the current byte
  logic              res_valid;
  event_t            res_kind;
  logic [BYTE_W-1:0] res_byte;
  logic [CNT_W-1:0]  res_cnt;
  logic [WIDE_W-1:0] res_len_wide;
  logic [LEN_W-1:0]  res_len;

  logic              is_payload;
  logic [BYTE_W-1:0] payload;
  logic              room;
  logic              stage_adv;

  // output register
  logic              out_valid_r;
  event_t            out_kind_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [NIB_W-1:0]  out_port_r;
  logic [NIB_W-1:0]  out_cmd_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_trunc_r;

  assign stage_adv   = in_valid_r && (!res_valid || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || stage_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_byte_r == FEND) phase_nxt = PH_AFTER_FEND;
      end
      PH_AFTER_FEND: begin
        if (in_byte_r != FEND) phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        if (in_byte_r == FEND) begin
          phase_nxt = PH_IDLE;
        end else if (in_byte_r == FESC) begin
          phase_nxt = PH_ESCAPE;
        end
      end
      PH_ESCAPE: begin
        if (in_byte_r == TFEND || in_byte_r == TFESC) begin
          phase_nxt = PH_DATA;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // payload recovery, counters and result
  always_comb begin
    is_payload = 1'b0;
    payload    = in_byte_r;
    if (phase_r == PH_DATA) begin
      is_payload = (in_byte_r != FEND) && (in_byte_r != FESC);
    end else if (phase_r == PH_ESCAPE) begin
      if (in_byte_r == TFEND) begin
        is_payload = 1'b1;
        payload    = FEND;
      end else if (in_byte_r == TFESC) begin
        is_payload = 1'b1;
        payload    = FESC;
      end
    end

    room = cnt_r < CNT_W'(MAX_FRAME_BYTES);

    port_nxt  = port_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    res_valid = 1'b0;
    res_kind  = EV_DATA;
    res_byte  = '0;
    res_cnt   = cnt_r;

    if (phase_r == PH_IDLE && in_byte_r == FEND) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end
    if (phase_r == PH_AFTER_FEND && in_byte_r != FEND) begin
      port_nxt = in_byte_r[BYTE_W-1 -: NIB_W];
      cmd_nxt  = in_byte_r[NIB_W-1:0];
    end
    if (is_payload) begin
      if (room) begin
        cnt_nxt   = cnt_r + 1'b1;
        res_cnt   = cnt_r + 1'b1;
        res_valid = 1'b1;
        res_kind  = EV_DATA;
        res_byte  = payload;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (phase_r == PH_DATA && in_byte_r == FEND && cnt_r != '0) begin
      res_valid = 1'b1;
      res_kind  = EV_DONE;
    end
    if (phase_r == PH_ESCAPE && !is_payload) begin
      res_valid = 1'b1;
      res_kind  = EV_ABORT;
    end

    // frame_length saturates at the field's maximum
    res_len_wide = WIDE_W'(res_cnt);
    if (res_len_wide > WIDE_W'(LEN_MAX)) begin
      res_len = LEN_MAX;
    end else begin
      res_len = LEN_W'(res_len_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      port_r  <= '0;
      cmd_r   <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (stage_adv) begin
      phase_r <= phase_nxt;
      port_r  <= port_nxt;
      cmd_r   <= cmd_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && res_valid) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= res_byte;
      out_port_r  <= port_r;
      out_cmd_r   <= cmd_r;
      out_len_r   <= res_len;
      out_trunc_r <= ovf_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_kind_r;
  assign out_ch.data_byte    = out_byte_r;
  assign out_ch.port_number  = out_port_r;
  assign out_ch.command_code = out_cmd_r;
  assign out_ch.frame_length = out_len_r;
  assign out_ch.truncated    = out_trunc_r;

endmodule
